### hdl/rvt_pkg.sv
`timescale 1ns / 1ps

package rvt_pkg;

  localparam int unsigned ENTRIES    = 64;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 8;

  typedef struct packed {
    logic                       opcode;
    logic signed [KEY_BITS-1:0] key_begin;
    logic signed [KEY_BITS-1:0] key_end;
    logic [VALUE_BITS-1:0]      new_value;
  } in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] status;
  } out_t;

  localparam logic       OP_LOOKUP = 1'b0;
  localparam logic       OP_ASSIGN = 1'b1;
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DEL,
    S_INS_E,
    S_INS_B
  } state_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_DEL,
    CMD_INS
  } cell_cmd_e;

  typedef struct packed {
    logic                       valid;
    logic signed [KEY_BITS-1:0] key;
    logic [VALUE_BITS-1:0]      value;
  } entry_t;

  typedef struct packed {
    cell_cmd_e                  cmd;
    logic signed [KEY_BITS-1:0] kb;
    logic signed [KEY_BITS-1:0] ke;
    entry_t                     new_entry;
  } cell_ctl_t;

  typedef struct packed {
    logic below_b;
    logic le_b;
    logic le_e;
  } cell_flags_t;

endpackage

### hdl/rvt_cell.sv
`timescale 1ns / 1ps

module rvt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rvt_pkg::cell_ctl_t  ctl_i,
  input  rvt_pkg::entry_t     left_i,
  input  rvt_pkg::entry_t     right_i,
  input  logic                prev_below_i,
  output rvt_pkg::entry_t     entry_o,
  output rvt_pkg::cell_flags_t flags_o
);

  rvt_pkg::entry_t entry_q, entry_d;

  always_comb begin
    flags_o.below_b = entry_q.valid && (entry_q.key < ctl_i.kb);
    flags_o.le_b    = entry_q.valid && (entry_q.key <= ctl_i.kb);
    flags_o.le_e    = entry_q.valid && (entry_q.key <= ctl_i.ke);
  end

  // cells at or past the insertion or deletion point move as one
  always_comb begin
    entry_d = entry_q;
    case (ctl_i.cmd)
      rvt_pkg::CMD_DEL: begin
        if (!flags_o.below_b) entry_d = right_i;
      end
      rvt_pkg::CMD_INS: begin
        if (!flags_o.below_b) entry_d = prev_below_i ? ctl_i.new_entry : left_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) entry_q <= '0;
    else         entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### hdl/range_value_table.sv
`timescale 1ns / 1ps
// lookup: the accepted beat is evaluated, then the result beat is registered
// assign: evaluate, one delete step per breakpoint removed, then end-key and begin-key insert steps
// empty or rejected assign: answered straight from the evaluate step
// one item in flight; the next beat is taken once the result beat has left
// reset clears all cells, the default value and the control state; no clearing pass

module range_value_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rvt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rvt_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [rvt_pkg::VALUE_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned N = rvt_pkg::ENTRIES;

  rvt_pkg::state_e  state_q, state_d;
  rvt_pkg::in_t     req_q;
  rvt_pkg::out_t    res_q;
  logic             out_valid_q;
  logic [rvt_pkg::VALUE_BITS-1:0] dflt_q, vb_q, ve_q;
  logic             ins_b_q, ins_e_q;

  rvt_pkg::cell_ctl_t   ctl;
  rvt_pkg::entry_t      ent [N];
  rvt_pkg::cell_flags_t flg [N];

  logic [N-1:0] below_v, leb_v, lee_v, valid_v, inr_v;

  // chain of cells, each linked to both neighbours
  for (genvar i = 0; i < N; i++) begin : g_cell
    rvt_pkg::entry_t left_w, right_w;
    logic            prev_below_w;
    if (i == 0) begin : g_first
      assign left_w       = '0;
      assign prev_below_w = 1'b1;
    end else begin : g_mid
      assign left_w       = ent[i-1];
      assign prev_below_w = flg[i-1].below_b;
    end
    if (i == N - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_next
      assign right_w = ent[i+1];
    end
    rvt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .left_i       (left_w),
      .right_i      (right_w),
      .prev_below_i (prev_below_w),
      .entry_o      (ent[i]),
      .flags_o      (flg[i])
    );
    assign below_v[i] = flg[i].below_b;
    assign leb_v[i]   = flg[i].le_b;
    assign lee_v[i]   = flg[i].le_e;
    assign valid_v[i] = ent[i].valid;
    assign inr_v[i]   = ent[i].valid && !flg[i].below_b && flg[i].le_e;
  end

  // value of the last cell whose flag is set, default when none is
  logic [rvt_pkg::VALUE_BITS-1:0] val_look, val_b, val_e;
  logic any_look, any_b, any_e;
  logic rm1, rm2;

  always_comb begin
    val_look = '0;
    val_b    = '0;
    val_e    = '0;
    rm2      = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (leb_v[i] && (i == N - 1 || !leb_v[(i+1) % N]))     val_look |= ent[i].value;
      if (below_v[i] && (i == N - 1 || !below_v[(i+1) % N])) val_b    |= ent[i].value;
      if (lee_v[i] && (i == N - 1 || !lee_v[(i+1) % N]))     val_e    |= ent[i].value;
      if (i < N - 1) rm2 |= inr_v[i] & inr_v[(i+1) % N];
    end
    any_look = |leb_v;
    any_b    = |below_v;
    any_e    = |lee_v;
    rm1      = |inr_v;
  end

  logic [rvt_pkg::VALUE_BITS-1:0] look_v, vb_w, ve_w;
  logic ins_b_w, ins_e_w, empty_w, ovf_w, full_w, n63_w;

  // removals happen one a cycle, so only zero, one or more than one matter here
  always_comb begin
    look_v  = any_look ? val_look : dflt_q;
    vb_w    = any_b ? val_b : dflt_q;
    ve_w    = any_e ? val_e : dflt_q;
    ins_b_w = req_q.new_value != vb_w;
    ins_e_w = ve_w != req_q.new_value;
    empty_w = req_q.key_begin >= req_q.key_end;
    full_w  = valid_v[N-1];
    n63_w   = valid_v[N-2] && !valid_v[N-1];
    ovf_w   = (full_w && !rm1 && (ins_b_w || ins_e_w))
            || (n63_w && !rm1 && ins_b_w && ins_e_w)
            || (full_w && rm1 && !rm2 && ins_b_w && ins_e_w);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rvt_pkg::S_IDLE:  if (in_valid_i && !in_stall_o) state_d = rvt_pkg::S_EVAL;
      rvt_pkg::S_EVAL: begin
        if (req_q.opcode == rvt_pkg::OP_LOOKUP || empty_w || ovf_w) state_d = rvt_pkg::S_IDLE;
        else                                                         state_d = rvt_pkg::S_DEL;
      end
      rvt_pkg::S_DEL:   if (!rm1) state_d = rvt_pkg::S_INS_E;
      rvt_pkg::S_INS_E: state_d = rvt_pkg::S_INS_B;
      rvt_pkg::S_INS_B: state_d = rvt_pkg::S_IDLE;
      default:          state_d = rvt_pkg::S_IDLE;
    endcase
  end

  // cell commands; end key goes in first so the begin key lands ahead of it
  always_comb begin
    ctl.cmd       = rvt_pkg::CMD_HOLD;
    ctl.kb        = req_q.key_begin;
    ctl.ke        = req_q.key_end;
    ctl.new_entry = '0;
    unique case (state_q)
      rvt_pkg::S_DEL: if (rm1) ctl.cmd = rvt_pkg::CMD_DEL;
      rvt_pkg::S_INS_E: begin
        if (ins_e_q) ctl.cmd = rvt_pkg::CMD_INS;
        ctl.new_entry = '{valid: 1'b1, key: req_q.key_end, value: ve_q};
      end
      rvt_pkg::S_INS_B: begin
        if (ins_b_q) ctl.cmd = rvt_pkg::CMD_INS;
        ctl.new_entry = '{valid: 1'b1, key: req_q.key_begin, value: req_q.new_value};
      end
      default: ctl.cmd = rvt_pkg::CMD_HOLD;
    endcase
  end

  assign in_stall_o = (state_q != rvt_pkg::S_IDLE) || out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rvt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      dflt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) dflt_q <= cfg_wdata_i;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == rvt_pkg::S_EVAL && state_d == rvt_pkg::S_IDLE) out_valid_q <= 1'b1;
      if (state_q == rvt_pkg::S_INS_B) out_valid_q <= 1'b1;
    end
  end

  // beat capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) req_q <= in_data_i;
    if (state_q == rvt_pkg::S_EVAL) begin
      vb_q    <= vb_w;
      ve_q    <= ve_w;
      ins_b_q <= ins_b_w;
      ins_e_q <= ins_e_w;
      if (req_q.opcode == rvt_pkg::OP_LOOKUP) begin
        res_q <= '{read_value: 8'(look_v), status: rvt_pkg::ST_DONE};
      end else if (empty_w) begin
        res_q <= '{read_value: 8'd0, status: rvt_pkg::ST_EMPTY};
      end else if (ovf_w) begin
        res_q <= '{read_value: 8'd0, status: rvt_pkg::ST_FULL};
      end else begin
        res_q <= '{read_value: 8'd0, status: rvt_pkg::ST_DONE};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

### hdl/rvt_checker.sv
`timescale 1ns / 1ps

module rvt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rvt_pkg::out_t out_data_o
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // no input beat while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken with result pending");

  // a result never appears in the cycle after an input beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("bad status code");

endmodule

bind range_value_table rvt_checker u_rvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### tb/range_value_table_checker.sv
`timescale 1ns / 1ps

module range_value_table_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  rvt_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  rvt_pkg::out_t out_data_i,
  input  logic          cfg_we_i,
  input  logic [rvt_pkg::VALUE_BITS-1:0] cfg_wdata_i,
  output int            fail_count_o,
  output int            pending_o
);

  logic signed [rvt_pkg::KEY_BITS-1:0] bp_key [rvt_pkg::ENTRIES];
  logic [rvt_pkg::VALUE_BITS-1:0]      bp_val [rvt_pkg::ENTRIES];
  int                                  bp_count;
  logic [rvt_pkg::VALUE_BITS-1:0]      dflt;
  rvt_pkg::out_t                       pending_q[$];

  assign pending_o = pending_q.size();

  // number of breakpoints below k, or at or below it when incl is set
  function automatic int keys_below(logic signed [rvt_pkg::KEY_BITS-1:0] k, bit incl);
    int n;
    n = 0;
    while (n < bp_count && (incl ? bp_key[n] <= k : bp_key[n] < k)) n++;
    return n;
  endfunction

  function automatic logic [rvt_pkg::VALUE_BITS-1:0] value_under(int n);
    return n > 0 ? bp_val[n-1] : dflt;
  endfunction

  function automatic rvt_pkg::out_t apply_beat(rvt_pkg::in_t b);
    rvt_pkg::out_t r;
    int lo, hi, tail, dst;
    bit ib, ie;
    logic [rvt_pkg::VALUE_BITS-1:0] vb, ve;
    logic signed [rvt_pkg::KEY_BITS-1:0] tk [rvt_pkg::ENTRIES];
    logic [rvt_pkg::VALUE_BITS-1:0] tv [rvt_pkg::ENTRIES];
    r = '0;
    if (b.opcode == rvt_pkg::OP_LOOKUP) begin
      r.read_value = value_under(keys_below(b.key_begin, 1'b1));
      r.status = rvt_pkg::ST_DONE;
      return r;
    end
    if (b.key_begin >= b.key_end) begin
      r.status = rvt_pkg::ST_EMPTY;
      return r;
    end
    lo = keys_below(b.key_begin, 1'b0);
    hi = keys_below(b.key_end, 1'b1);
    vb = value_under(lo);
    ve = value_under(hi);
    ib = b.new_value != vb;
    ie = ve != b.new_value;
    tail = bp_count - hi;
    dst = lo + ib + ie;
    if (dst + tail > rvt_pkg::ENTRIES) begin
      r.status = rvt_pkg::ST_FULL;
      return r;
    end
    tk = bp_key;
    tv = bp_val;
    for (int i = 0; i < tail; i++) begin
      bp_key[dst+i] = tk[hi+i];
      bp_val[dst+i] = tv[hi+i];
    end
    if (ib) begin
      bp_key[lo] = b.key_begin;
      bp_val[lo] = b.new_value;
    end
    if (ie) begin
      bp_key[lo+ib] = b.key_end;
      bp_val[lo+ib] = ve;
    end
    bp_count = dst + tail;
    r.status = rvt_pkg::ST_DONE;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rvt_pkg::out_t want;
    if (!rst_ni) begin
      bp_count = 0;
      dflt = '0;
      fail_count_o <= 0;
      pending_q.delete();
    end else begin
      if (cfg_we_i) dflt = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) pending_q.push_back(apply_beat(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_q.pop_front();
          if (want.read_value !== out_data_i.read_value || want.status !== out_data_i.status)
          begin
            $display("%0t: mismatch, expected value %h status %0d, actual value %h status %0d",
                     $time, want.read_value, want.status,
                     out_data_i.read_value, out_data_i.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

### tb/tb_range_value_table.sv
`timescale 1ns / 1ps

module tb_range_value_table;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rvt_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rvt_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [rvt_pkg::VALUE_BITS-1:0] cfg_wdata = '0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   rx_wait = 0;
  bit   hold_long = 1'b0;   // receiver holds off for a long stretch

  // keys drawn from a small pool so that intervals overlap and breakpoints collide
  logic signed [rvt_pkg::KEY_BITS-1:0] key_pool [16];

  always #5 clk = ~clk;

  range_value_table DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  range_value_table_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog: generous bound on the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("tb_range_value_table: done, errors");
      $finish;
    end
  end

  // receiver stalls each result beat for a random wait, or holds off on request
  always @(negedge clk) begin
    if (hold_long) begin
      out_stall <= 1'b1;
    end else if (out_valid && rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait <= rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) rx_wait <= $urandom_range(0, 17);
    end
  end

  // send one beat, after a random gap unless gaps are off
  task automatic send_beat(input rvt_pkg::in_t b, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_op(input logic op, input logic signed [rvt_pkg::KEY_BITS-1:0] kb,
                         input logic signed [rvt_pkg::KEY_BITS-1:0] ke,
                         input logic [rvt_pkg::VALUE_BITS-1:0] v, input bit gaps);
    rvt_pkg::in_t b;
    b.opcode = op;
    b.key_begin = kb;
    b.key_end = ke;
    b.new_value = v;
    send_beat(b, gaps);
  endtask

  // drop valid, drain everything then allow an assign's worst-case shift time
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (rvt_pkg::ENTRIES + 10) @(negedge clk);
  endtask

  task automatic write_default(input logic [rvt_pkg::VALUE_BITS-1:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [rvt_pkg::KEY_BITS-1:0] pick_key(bit wide);
    return wide ? $urandom() : key_pool[$urandom_range(0, 15)];
  endfunction

  // random phase: mostly overlapping assigns and lookups on pooled keys
  task automatic random_phase(input int n, input bit gaps);
    logic signed [rvt_pkg::KEY_BITS-1:0] a, b;
    bit wide;
    for (int i = 0; i < n; i++) begin
      wide = ($urandom_range(0, 9) == 0);
      a = pick_key(wide);
      b = pick_key(wide);
      if ($urandom_range(0, 5) != 0 && a > b) {a, b} = {b, a};
      send_op(1'($urandom_range(0, 1)), a, b,
              8'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3)), gaps);
    end
  endtask

  // many distinct adjacent intervals to fill the table and hit the capacity check
  task automatic fill_phase(input int n);
    logic signed [rvt_pkg::KEY_BITS-1:0] base;
    base = $urandom();
    if (base > 32'sh7000_0000) base = 32'sh1000_0000;
    for (int i = 0; i < n; i++) begin
      send_op(rvt_pkg::OP_ASSIGN, base + 4 * i, base + 4 * i + 2, i[7:0] + 8'd1,
              ($urandom_range(0, 3) == 0));
      if (i % 8 == 0) send_op(rvt_pkg::OP_LOOKUP, base + 4 * i + 1, $urandom(),
                              8'($urandom()), 1'b0);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom_range(0, 60) - 30;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sh8000_0001;
    key_pool[3] = 32'sh7fff_fffe;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, both operations, empty interval, default change
    send_op(rvt_pkg::OP_LOOKUP, 32'sh8000_0000, 32'sh7fff_ffff, 8'hff, 1'b1);
    send_op(rvt_pkg::OP_LOOKUP, 32'sh7fff_ffff, 32'sh8000_0000, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_ASSIGN, 32'sh8000_0000, 32'sh7fff_ffff, 8'hff, 1'b1);
    send_op(rvt_pkg::OP_LOOKUP, 32'sh8000_0000, 0, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_LOOKUP, 32'sh7fff_fffe, 0, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_LOOKUP, 32'sh7fff_ffff, 0, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_ASSIGN, 5, 5, 8'h11, 1'b1);
    send_op(rvt_pkg::OP_ASSIGN, 6, 5, 8'h11, 1'b1);
    send_op(rvt_pkg::OP_ASSIGN, 32'sh7fff_ffff, 32'sh8000_0000, 8'h22, 1'b1);
    send_op(rvt_pkg::OP_ASSIGN, -10, 10, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_ASSIGN, -5, 5, 8'hff, 1'b1);
    send_op(rvt_pkg::OP_ASSIGN, 0, 20, 8'h5a, 1'b1);
    send_op(rvt_pkg::OP_LOOKUP, -6, 0, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_LOOKUP, -5, 0, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_LOOKUP, 19, 0, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_LOOKUP, 20, 0, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_ASSIGN, -100, 100, 8'ha5, 1'b1);
    write_default(8'hff);
    send_op(rvt_pkg::OP_LOOKUP, 32'sh8000_0000, 0, 8'h00, 1'b1);
    send_op(rvt_pkg::OP_ASSIGN, 32'sh8000_0000, -100, 8'hff, 1'b1);
    send_op(rvt_pkg::OP_LOOKUP, 100, 0, 8'h00, 1'b1);

    random_phase(300, 1'b1);
    write_default(8'h00);
    fill_phase(90);
    random_phase(200, 1'b0);

    // long receiver hold-off while the sender keeps offering beats
    fork
      begin
        hold_long = 1'b1;
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
      end
      random_phase(20, 1'b0);
    join

    // sender pause until every result has arrived, then a default change
    write_default(8'h03);
    random_phase(300, 1'b1);
    write_default(8'($urandom_range(1, 254)));
    fill_phase(70);
    random_phase(400, 1'b1);

    drain();
    if (fail_count == 0) begin
      $display("tb_range_value_table: done, clean");
    end else begin
      $display("tb_range_value_table: done, errors");
    end
    $finish;
  end

endmodule
